// File: rtl/rag_pkg.sv
package rag_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;

endpackage

// File: rtl/rag_front.sv
module rag_front
    import rag_pkg::*;
#(
    parameter int IN_WIDTH = 16,
    parameter int PW = 2 * IN_WIDTH + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           cmd,
    input  logic [IN_WIDTH-1:0]  num_a,
    input  logic [IN_WIDTH-1:0]  den_a,
    input  logic [IN_WIDTH-1:0]  num_b,
    input  logic [IN_WIDTH-1:0]  den_b,
    input  logic                 q_full,
    output logic                 busy,
    output logic                 q_push,
    output logic signed [PW-1:0] q_n,
    output logic signed [PW-1:0] q_m,
    output logic                 q_dz
);

    // products, then sum; one item at a time in front
    typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM} fstate_t;

    fstate_t                          state_reg;
    logic [1:0]                       cmd_reg;
    logic signed [IN_WIDTH-1:0]       a_reg, c_reg, b_reg, d_reg;
    logic signed [2*IN_WIDTH-1:0]     p0_reg, p1_reg, p2_reg;
    logic signed [PW-1:0]             n_raw, m_raw;
    logic                             dz_raw;
    logic signed [IN_WIDTH-1:0]       x1, x2, y1, y2;

    assign busy   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_SUM) && !q_full;
    assign q_n    = n_raw;
    assign q_m    = m_raw;
    assign q_dz   = dz_raw;

    always_comb
    begin
        case (cmd_t'(cmd_reg))
            CMD_MUL:
            begin
                x1 = a_reg; y1 = b_reg; x2 = c_reg; y2 = d_reg;
            end
            CMD_DIV:
            begin
                x1 = a_reg; y1 = d_reg; x2 = c_reg; y2 = b_reg;
            end
            default:
            begin
                x1 = b_reg; y1 = c_reg; x2 = c_reg; y2 = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        a_reg     <= num_a;
                        c_reg     <= den_a;
                        b_reg     <= num_b;
                        d_reg     <= den_b;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    p0_reg    <= a_reg * d_reg;
                    p1_reg    <= x1 * y1;
                    p2_reg    <= x2 * y2;
                    state_reg <= F_SUM;
                end
                F_SUM:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (cmd_t'(cmd_reg))
            CMD_ADD: n_raw = PW'(p0_reg) + PW'(p1_reg);
            CMD_SUB: n_raw = PW'(p0_reg) - PW'(p1_reg);
            default: n_raw = PW'(p1_reg);
        endcase
        m_raw  = PW'(p2_reg);
        dz_raw = (cmd_t'(cmd_reg) == CMD_DIV) && (b_reg == '0);
    end

endmodule

// File: rtl/rag_queue.sv
module rag_queue
#(
    parameter int W = 8,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// File: rtl/rag_back.sv
module rag_back
    import rag_pkg::*;
#(
    parameter int PW = 33
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic signed [PW-1:0] q_n,
    input  logic signed [PW-1:0] q_m,
    input  logic                 q_dz,
    output logic                 q_pop,
    output logic                 done,
    output logic [NUM_OUT_W-1:0] res_num,
    output logic [DEN_OUT_W-1:0] res_den,
    output logic                 div_zero
);

    // one restoring divider, a bit a step: euclid remainders, then two exact quotients
    typedef enum logic [2:0] {B_IDLE, B_LOAD, B_REM, B_QN, B_QM, B_OUT} bstate_t;

    localparam int CW = $clog2(PW + 1);

    bstate_t           state_reg;
    logic [PW-1:0]     n_reg, m_reg;
    logic              sn_reg, sm_reg, dz_reg;
    logic [PW-1:0]     x_reg, y_reg;       // euclid pair
    logic [PW-1:0]     dvd_reg, quo_reg, rem_reg, dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     qn_reg;
    logic [PW:0]       trial;
    logic [PW-1:0]     rem_sh;

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        rem_sh = {rem_reg[PW-2:0], dvd_reg[PW-1]};
        trial  = {rem_reg, dvd_reg[PW-1]} - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sn_reg    <= q_n[PW-1];
                        sm_reg    <= q_m[PW-1];
                        n_reg     <= q_n[PW-1] ? -q_n : q_n;
                        m_reg     <= q_m[PW-1] ? -q_m : q_m;
                        x_reg     <= q_n[PW-1] ? -q_n : q_n;
                        y_reg     <= q_m[PW-1] ? -q_m : q_m;
                        dz_reg    <= q_dz;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD:
                begin
                    // x_reg holds gcd when y_reg is zero
                    if (dz_reg || (y_reg == '0))
                    begin
                        if (dz_reg || (x_reg == '0))
                        begin
                            res_num   <= '0;
                            res_den   <= '0;
                            div_zero  <= dz_reg;
                            done      <= 1'b1;
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            dvd_reg   <= n_reg;
                            dvs_reg   <= x_reg;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= B_QN;
                        end
                    end
                    else
                    begin
                        dvd_reg   <= x_reg;
                        dvs_reg   <= y_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= B_REM;
                    end
                end
                B_REM, B_QN, B_QM:
                begin
                    dvd_reg <= {dvd_reg[PW-2:0], ~trial[PW]};
                    rem_reg <= trial[PW] ? rem_sh : trial[PW-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(PW - 1))
                    begin
                        if (state_reg == B_REM)
                        begin
                            x_reg     <= y_reg;
                            y_reg     <= trial[PW] ? rem_sh : trial[PW-1:0];
                            state_reg <= B_LOAD;
                        end
                        else if (state_reg == B_QN)
                        begin
                            qn_reg    <= {dvd_reg[PW-2:0], ~trial[PW]};
                            dvd_reg   <= m_reg;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= B_QM;
                        end
                        else
                        begin
                            quo_reg   <= {dvd_reg[PW-2:0], ~trial[PW]};
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_OUT:
                begin
                    // sign extend to the field width, or truncate when wider
                    res_num   <= NUM_OUT_W'($signed(sn_reg ? -qn_reg : qn_reg));
                    res_den   <= DEN_OUT_W'($signed(sm_reg ? -quo_reg : quo_reg));
                    div_zero  <= 1'b0;
                    done      <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/rational_alu_gcd_reduce.sv
// rational arithmetic unit with gcd reduction
//
// command channel: pulse start with cmd, num_a, den_a, num_b, den_b while busy
// is low; the item is taken at that edge. cmd selects add, subtract, multiply
// or divide of num_a/den_a and num_b/den_b.
// result channel: done is high for exactly one cycle with res_num, res_den
// and div_zero; the receiver cannot stall, so nothing waits on it.
// the front end forms the cross products and pushes the raw numerator and
// denominator into a two-entry queue, waiting while it is full; the back end
// pops it and runs euclid's loop on the magnitudes with one restoring divider,
// one bit a cycle, reloading between divisions, then two exact divisions.
// the shared divider sets the rate, one item at a time in back.
// divide by a zero fraction raises div_zero with zero results.
// reset clears the queue and both sequencers; no result is pending afterwards.
module rational_alu_gcd_reduce
    import rag_pkg::*;
#(
    parameter int IN_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [IN_WIDTH-1:0]  num_a,
    input  logic [IN_WIDTH-1:0]  den_a,
    input  logic [IN_WIDTH-1:0]  num_b,
    input  logic [IN_WIDTH-1:0]  den_b,
    output logic                 done,
    output logic [NUM_OUT_W-1:0] res_num,
    output logic [DEN_OUT_W-1:0] res_den,
    output logic                 div_zero
);

    localparam int PW = 2 * IN_WIDTH + 1;

    logic              q_push, q_pop, q_full, q_empty, q_dz;
    logic [PW-1:0]     q_n, q_m, o_n, o_m;
    logic              o_dz;

    // front is free again once its item sits in the queue
    rag_front #(.IN_WIDTH(IN_WIDTH), .PW(PW)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start),
        .cmd(cmd), .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .q_full(q_full), .busy(busy), .q_push(q_push),
        .q_n(q_n), .q_m(q_m), .q_dz(q_dz)
    );

    rag_queue #(.W(2 * PW + 1), .DEPTH(2)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .wdata({q_dz, q_n, q_m}),
        .pop(q_pop), .rdata({o_dz, o_n, o_m}), .full(q_full), .empty(q_empty)
    );

    rag_back #(.PW(PW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty),
        .q_n(o_n), .q_m(o_m), .q_dz(o_dz), .q_pop(q_pop),
        .done(done), .res_num(res_num), .res_den(res_den), .div_zero(div_zero)
    );

endmodule

// File: verif/rational_alu_gcd_reduce_test.sv
`timescale 1ns / 1ps

module rational_alu_gcd_reduce_test;
    import rag_pkg::*;

    localparam int W = 16;
    // euclid on 32-bit magnitudes: ~46 steps worst case, plus the two exact divisions
    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 64'd10_000_000;

    typedef struct {
        cmd_t               op;
        logic signed [W-1:0] na;
        logic signed [W-1:0] da;
        logic signed [W-1:0] nb;
        logic signed [W-1:0] db;
    } frac_pair_t;

    typedef struct {
        logic [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0] den;
        logic                 dz;
    } reduced_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] cmd = '0;
    logic [W-1:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
    logic done;
    logic [NUM_OUT_W-1:0] res_num;
    logic [DEN_OUT_W-1:0] res_den;
    logic div_zero;

    frac_pair_t pending_items[$];
    reduced_t   expected_fracs[$];
    int  mismatches = 0;
    longint cycle_count = 0;
    bit  drain_hold = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;

    rational_alu_gcd_reduce #(.IN_WIDTH(W)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .done(done), .res_num(res_num), .res_den(res_den), .div_zero(div_zero)
    );

    always #5 clk = ~clk;

    // euclid on magnitudes, then exact division of both raw values
    function automatic reduced_t reduce_fraction(frac_pair_t it);
        reduced_t r;
        longint a, c, b, d, n, m;
        longint unsigned x, y, t;
        a = it.na; c = it.da; b = it.nb; d = it.db;
        r.num = '0; r.den = '0; r.dz = 1'b0;
        case (it.op)
            CMD_ADD: begin n = a * d + b * c; m = c * d; end
            CMD_SUB: begin n = a * d - b * c; m = c * d; end
            CMD_MUL: begin n = a * b; m = c * d; end
            default:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                    return r;
                end
                n = a * d;
                m = c * b;
            end
        endcase
        x = (n < 0) ? -n : n;
        y = (m < 0) ? -m : m;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0)
            return r;
        n = n / longint'(x);
        m = m / longint'(x);
        r.num = n[NUM_OUT_W-1:0];
        r.den = m[DEN_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'd1;
            4: return 16'd0;
            5: return W'($urandom_range(0, 15)) - 16'd8;
            6: return W'($urandom_range(0, 255));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_item(cmd_t op, logic [W-1:0] na, logic [W-1:0] da,
                            logic [W-1:0] nb, logic [W-1:0] db);
        frac_pair_t it;
        it.op = op; it.na = na; it.da = da; it.nb = nb; it.db = db;
        pending_items.push_back(it);
    endtask

    // driver: bursts with random gaps; holds off entirely while drain_hold is set
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                pending_items.pop_front();
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (drain_hold || pending_items.size() == 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                frac_pair_t it;
                // head of the queue; an item just taken is already gone
                it = pending_items[0];
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
                start <= 1'b1;
                cmd <= it.op;
                num_a <= it.na; den_a <= it.da; num_b <= it.nb; den_b <= it.db;
            end
        end
    end

    // predictor hook: an item is accepted at the edge where start is high and busy low
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            frac_pair_t it;
            it.op = cmd_t'(cmd);
            it.na = num_a; it.da = den_a; it.nb = num_b; it.db = den_b;
            expected_fracs.push_back(reduce_fraction(it));
        end
    end

    // monitor: done marks one result; compared against the oldest expectation
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_fracs.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result num=%h den=%h dz=%b",
                             res_num, res_den, div_zero);
            end
            else
            begin
                reduced_t e;
                e = expected_fracs.pop_front();
                if (e.num !== res_num || e.den !== res_den || e.dz !== div_zero)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp num=%h den=%h dz=%b got num=%h den=%h dz=%b",
                                 e.num, e.den, e.dz, res_num, res_den, div_zero);
                end
            end
        end
    end

    // safety net against a hang
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        cmd_t ops[4];
        ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};

        // directed: every operation, field extremes, zero-fraction divide,
        // zero denominators and both raw values zero
        foreach (ops[i])
        begin
            add_item(ops[i], 16'd1, 16'd2, 16'd1, 16'd3);
            add_item(ops[i], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            add_item(ops[i], 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        end
        add_item(CMD_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
        add_item(CMD_DIV, 16'h8000, 16'hffff, 16'd0, 16'h8000);
        add_item(CMD_ADD, 16'd3, 16'd0, 16'd5, 16'd4);
        add_item(CMD_MUL, 16'hfff9, 16'd0, 16'd2, 16'd0);
        add_item(CMD_SUB, 16'd0, 16'd0, 16'd0, 16'd0);
        add_item(CMD_MUL, 16'd0, 16'd0, 16'd9, 16'd0);
        add_item(CMD_SUB, 16'd6, 16'd4, 16'd6, 16'd4);
        add_item(CMD_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_item(CMD_DIV, 16'd0, 16'd5, 16'd3, 16'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 600; i++)
        begin
            if (i == 300)
            begin
                // pause until every expected result is home
                wait (pending_items.size() == 0);
                @(posedge clk);
                drain_hold = 1'b1;
                wait (expected_fracs.size() == 0 && !busy);
                @(posedge clk);
                drain_hold = 1'b0;
            end
            add_item(cmd_t'($urandom_range(0, 3)), pick_value(), pick_value(),
                     pick_value(), pick_value());
        end

        // the last item's expectation lands at its accepting edge
        wait (pending_items.size() == 0);
        @(posedge clk);
        wait (expected_fracs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_fracs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
